// ===== design/mdd_pkg.sv =====
// shared types and constants for the masked depth deprojection unit
// command and status words between controller and datapath, register indexes, reset values
// no dependencies
package mdd_pkg;

  // default counter width, legal range 8 to 14
  localparam int COORD_BITS_DEF = 12;

  // field widths
  localparam int DEPTH_W   = 16;
  localparam int MASK_W    = 8;
  localparam int SIZE_W    = 13;
  localparam int CENTER_W  = 16;
  localparam int INV_W     = 25;
  localparam int XY_W      = 37;
  localparam int Z_W       = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 25;

  // reciprocal is multiplied in two slices: low bits, then the rest
  localparam int INV_LO_W = 12;

  // product scale: Q4 * Q24 = Q28, result in Q8
  localparam int OUT_SHIFT = 20;

  localparam logic [MASK_W-1:0] MASK_OBJECT = 8'hFF;
  localparam logic [XY_W-1:0]   XY_MAX      = 37'h0F_FFFF_FFFF;
  localparam logic [XY_W:0]     XY_NEG_LIM  = 38'h10_0000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL_Q4 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW_Q4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_COL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_ROW = 3'd5;

  // register reset values
  localparam logic [SIZE_W-1:0]   IMAGE_WIDTH_RST   = 13'd640;
  localparam logic [SIZE_W-1:0]   IMAGE_HEIGHT_RST  = 13'd480;
  localparam logic [CENTER_W-1:0] CENTER_COL_RST    = 16'd5022;
  localparam logic [CENTER_W-1:0] CENTER_ROW_RST    = 16'd3945;
  localparam logic [INV_W-1:0]    INV_FOCAL_COL_RST = 25'd27202;
  localparam logic [INV_W-1:0]    INV_FOCAL_ROW_RST = 25'd27188;

  typedef struct packed {
    logic accept;    // latch the incoming word, advance raster counters
    logic mul_md;    // offset magnitude times depth
    logic mul_lo;    // times low slice of reciprocal
    logic mul_hi;    // times high slice of reciprocal, low product to accumulator
    logic acc_add;   // fold in high product
    logic load_out;  // round, saturate and fill the output register
  } mdd_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } mdd_status_t;

endpackage

// ===== design/mdd_ctrl.sv =====
// sequencing state machine for the masked depth deprojection unit
// depends on mdd_pkg for the command and status words
module mdd_ctrl
  import mdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  mdd_status_t status,
  output mdd_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MD   = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_HI   = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MD;
        end
      end
      ST_MD: begin
        cmd.mul_md = 1'b1;
        state_next = ST_LO;
      end
      ST_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_RND;
      end
      ST_RND: begin
        // wait here until the output register can take the word
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ===== design/mdd_dpath.sv =====
// datapath for the masked depth deprojection unit: raster counters,
// per-axis multiplier and accumulator, rounding and output register
// depends on mdd_pkg
module mdd_dpath
  import mdd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mdd_cmd_t                   cmd,
  output mdd_status_t                status,
  input  logic [SIZE_W-1:0]          image_width,
  input  logic [SIZE_W-1:0]          image_height,
  input  logic [CENTER_W-1:0]        center_col_q4,
  input  logic [CENTER_W-1:0]        center_row_q4,
  input  logic [INV_W-1:0]           inv_focal_col,
  input  logic [INV_W-1:0]           inv_focal_row,
  input  logic [DEPTH_W-1:0]         depth_mm,
  input  logic [MASK_W-1:0]          mask_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       point_valid,
  output logic signed [XY_W-1:0]     point_x,
  output logic signed [XY_W-1:0]     point_y,
  output logic [Z_W-1:0]             point_z,
  output logic                       frame_last
);

  localparam int MAG_W = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
  localparam int MD_W  = MAG_W + DEPTH_W;
  localparam int PW    = MD_W + DEPTH_W;
  localparam int ACC_W = MD_W + INV_W;
  localparam int RW    = ACC_W + 1 - OUT_SHIFT;
  localparam int HI_W  = INV_W - INV_LO_W;
  localparam logic [31:0] SIZE_MAX = 32'd1 << COORD_BITS;
  localparam logic [ACC_W:0] HALF  = (ACC_W+1)'(1) << (OUT_SHIFT - 1);

  // round to nearest with ties toward plus infinity, saturate to 37 bits
  function automatic logic [XY_W-1:0] round_sat(input logic [ACC_W-1:0] acc,
                                                input logic neg);
    logic [ACC_W:0] sum;
    logic [RW-1:0]  r;
    logic [XY_W-1:0] res;
    sum = {1'b0, acc} + (neg ? (HALF - (ACC_W+1)'(1)) : HALF);
    r   = sum[ACC_W:OUT_SHIFT];
    if (!neg) begin
      res = (r > RW'(XY_MAX)) ? XY_MAX : r[XY_W-1:0];
    end else begin
      if (r > RW'(XY_NEG_LIM)) begin
        r = RW'(XY_NEG_LIM);
      end
      res = XY_W'(0) - r[XY_W-1:0];
    end
    return res;
  endfunction

  // raster position
  logic [COORD_BITS-1:0] col_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] col_lim;
  logic [COORD_BITS-1:0] row_lim;
  logic [31:0]           w_m1;
  logic [31:0]           h_m1;
  logic                  col_last;
  logic                  row_last;

  // captured word
  logic [DEPTH_W-1:0] d_reg;
  logic               valid_reg;
  logic               last_reg;
  logic               neg_x;
  logic               neg_y;
  logic [MAG_W-1:0]   mag_x;
  logic [MAG_W-1:0]   mag_y;

  // pixel position and center at accept time, for the offset magnitudes
  logic [MAG_W-1:0] pos_x;
  logic [MAG_W-1:0] pos_y;
  logic [MAG_W-1:0] cen_x;
  logic [MAG_W-1:0] cen_y;

  // multiply and accumulate
  logic [MD_W-1:0]    md_x;
  logic [MD_W-1:0]    md_y;
  logic [PW-1:0]      prod_x;
  logic [PW-1:0]      prod_y;
  logic [ACC_W-1:0]   acc_x;
  logic [ACC_W-1:0]   acc_y;
  logic [MD_W-1:0]    mul_a_x;
  logic [MD_W-1:0]    mul_a_y;
  logic [DEPTH_W-1:0] mul_b_x;
  logic [DEPTH_W-1:0] mul_b_y;
  logic [PW-1:0]      mul_x;
  logic [PW-1:0]      mul_y;

  // a size of zero or above the counter range wraps at the full range
  assign w_m1 = 32'(image_width) - 32'd1;
  assign h_m1 = 32'(image_height) - 32'd1;
  assign col_lim = (image_width == '0 || 32'(image_width) > SIZE_MAX) ? '1 :
                   w_m1[COORD_BITS-1:0];
  assign row_lim = (image_height == '0 || 32'(image_height) > SIZE_MAX) ? '1 :
                   h_m1[COORD_BITS-1:0];
  assign col_last = (col_count == col_lim);
  assign row_last = (row_count == row_lim);

  assign pos_x = MAG_W'({col_count, 4'b0000});
  assign pos_y = MAG_W'({row_count, 4'b0000});
  assign cen_x = MAG_W'(center_col_q4);
  assign cen_y = MAG_W'(center_row_q4);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_reg     <= depth_mm;
      valid_reg <= (mask_value == MASK_OBJECT) && (depth_mm != '0);
      last_reg  <= col_last && row_last;
      neg_x     <= cen_x > pos_x;
      neg_y     <= cen_y > pos_y;
      mag_x     <= (cen_x > pos_x) ? cen_x - pos_x : pos_x - cen_x;
      mag_y     <= (cen_y > pos_y) ? cen_y - pos_y : pos_y - cen_y;
    end
  end

  // operand select for the one multiplier of each axis
  always_comb begin
    mul_a_x = md_x;
    mul_a_y = md_y;
    if (cmd.mul_md) begin
      mul_a_x = MD_W'(mag_x);
      mul_a_y = MD_W'(mag_y);
      mul_b_x = d_reg;
      mul_b_y = d_reg;
    end else if (cmd.mul_lo) begin
      mul_b_x = DEPTH_W'(inv_focal_col[INV_LO_W-1:0]);
      mul_b_y = DEPTH_W'(inv_focal_row[INV_LO_W-1:0]);
    end else begin
      mul_b_x = DEPTH_W'(inv_focal_col[INV_W-1 -: HI_W]);
      mul_b_y = DEPTH_W'(inv_focal_row[INV_W-1 -: HI_W]);
    end
  end

  assign mul_x = PW'(mul_a_x) * PW'(mul_b_x);
  assign mul_y = PW'(mul_a_y) * PW'(mul_b_y);

  always_ff @(posedge clk) begin
    if (cmd.mul_md) begin
      md_x <= mul_x[MD_W-1:0];
      md_y <= mul_y[MD_W-1:0];
    end
    if (cmd.mul_lo) begin
      prod_x <= mul_x;
      prod_y <= mul_y;
    end
    if (cmd.mul_hi) begin
      acc_x  <= ACC_W'(prod_x);
      acc_y  <= ACC_W'(prod_y);
      prod_x <= mul_x;
      prod_y <= mul_y;
    end
    if (cmd.acc_add) begin
      acc_x <= acc_x + (ACC_W'(prod_x) << INV_LO_W);
      acc_y <= acc_y + (ACC_W'(prod_y) << INV_LO_W);
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_valid <= valid_reg;
      frame_last  <= last_reg;
      point_x     <= valid_reg ? $signed(round_sat(acc_x, neg_x)) : '0;
      point_y     <= valid_reg ? $signed(round_sat(acc_y, neg_y)) : '0;
      point_z     <= valid_reg ? {d_reg, 8'h00} : '0;
    end
  end

endmodule

// ===== design/masked_depth_deprojection_unit.sv =====
// masked depth deprojection unit, top level
// holds the configuration registers, joins mdd_ctrl and mdd_dpath; uses mdd_pkg
//
// usage:
// - input channel: in_valid / in_stall carry one depth pixel word (depth_mm, mask_value)
//   in raster order; a word is taken at a clock edge with in_valid high and in_stall low
// - output channel: out_valid / out_stall carry one point word per pixel: point_valid,
//   point_x / point_y (signed, 1/256 mm), point_z (1/256 mm) and frame_last
// - order: a taken pixel passes ST_MD, ST_LO, ST_HI, ST_ACC, ST_RND, and its point word
//   enters the output register as ST_RND ends; no pixel is taken before that load;
//   each axis has one 32 by 16 multiplier that runs offset times depth, then the two
//   slices of the 25-bit reciprocal, then the accumulate and the rounding step
// - the output register lets the next pixel in while a point still waits to be taken;
//   when the receiver stalls, the finished point holds in the rounding step and
//   in_stall stays high until the output register frees
// - reset: raster counters to zero, registers to their defaults, output empty
// - configuration writes through cfg_write_en / cfg_index / cfg_data, only while idle;
//   unknown indexes are dropped
module masked_depth_deprojection_unit
  import mdd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // pixel words in
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DEPTH_W-1:0]     depth_mm,
  input  logic [MASK_W-1:0]      mask_value,
  // point words out
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   point_valid,
  output logic signed [XY_W-1:0] point_x,
  output logic signed [XY_W-1:0] point_y,
  output logic [Z_W-1:0]         point_z,
  output logic                   frame_last
);

  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  logic [CENTER_W-1:0] center_col_q4;
  logic [CENTER_W-1:0] center_row_q4;
  logic [INV_W-1:0]    inv_focal_col;
  logic [INV_W-1:0]    inv_focal_row;

  mdd_cmd_t    cmd;
  mdd_status_t status;

  // register file, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
      center_col_q4 <= CENTER_COL_RST;
      center_row_q4 <= CENTER_ROW_RST;
      inv_focal_col <= INV_FOCAL_COL_RST;
      inv_focal_row <= INV_FOCAL_ROW_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[SIZE_W-1:0];
        REG_CENTER_COL_Q4: center_col_q4 <= cfg_data[CENTER_W-1:0];
        REG_CENTER_ROW_Q4: center_row_q4 <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_COL: inv_focal_col <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_ROW: inv_focal_row <= cfg_data[INV_W-1:0];
        default: begin
          // index beyond the list, dropped
        end
      endcase
    end
  end

  // sequencer: one pixel at a time through the multiply steps
  mdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // counters, arithmetic and output register
  mdd_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .image_width   (image_width),
    .image_height  (image_height),
    .center_col_q4 (center_col_q4),
    .center_row_q4 (center_row_q4),
    .inv_focal_col (inv_focal_col),
    .inv_focal_row (inv_focal_row),
    .depth_mm      (depth_mm),
    .mask_value    (mask_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_valid   (point_valid),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .frame_last    (frame_last)
  );

endmodule

// ===== design/mdd_checker.sv =====
// port-level checks for the masked depth deprojection unit
// bound to masked_depth_deprojection_unit; depends on mdd_pkg
module mdd_checker
  import mdd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   point_valid,
  input logic signed [XY_W-1:0] point_x,
  input logic signed [XY_W-1:0] point_y,
  input logic [Z_W-1:0]         point_z,
  input logic                   frame_last
);

  // a stalled point word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z) && $stable(point_valid) && $stable(frame_last))
    else $error("stalled point word changed");

  // one pixel in flight: input closes right after a word is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second pixel taken while one is in flight");

  // masked or empty pixels carry a zero point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("invalid point with nonzero coordinates");

  // z is depth scaled by 256 and nonzero on a valid point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid |-> point_z[7:0] == 8'h00 && point_z != '0)
    else $error("bad z on valid point");

endmodule

bind masked_depth_deprojection_unit mdd_checker u_mdd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .point_valid (point_valid),
  .point_x     (point_x),
  .point_y     (point_y),
  .point_z     (point_z),
  .frame_last  (frame_last)
);

// ===== sim/testbench.sv =====
// testbench for masked_depth_deprojection_unit: directed table, then random raster streams
// every point word is checked field by field against an in-bench pinhole projection model or a typed-in point
// depends on design/mdd_pkg.sv and design/masked_depth_deprojection_unit.sv
module testbench;
  import mdd_pkg::*;

  localparam int RASTER_BITS = COORD_BITS_DEF;
  localparam logic [SIZE_W-1:0] RASTER_SPAN = SIZE_W'(1) << RASTER_BITS;
  // extra wait after the owed points have come out, as a margin
  localparam int SETTLE_CYCLES = 8;

  // indexes past the end of the register list, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_B = 3'd7;

  // rounding and saturation constants for the projected axes
  localparam logic [63:0] ROUND_HALF = 64'd1 << (OUT_SHIFT - 1);
  localparam logic [63:0] SAT_POS    = 64'(XY_MAX);
  localparam logic [63:0] SAT_NEG    = 64'(XY_NEG_LIM);
  localparam longint      XY_FLOOR   = -(64'sd1 <<< 36);
  localparam logic [INV_W-1:0] RCP_UNITY = 25'h100_0000;  // 1.0 in Q1.24
  localparam logic [INV_W-1:0] RCP_TIE   = 25'h008_0000;  // 1/32, makes exact half steps

  typedef struct {
    logic                   vld;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   last;
  } point_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [DEPTH_W-1:0]   depth;
    logic [MASK_W-1:0]    mask;
    logic                 known;  // expected point typed into the row
    point_t               want;
  } plan_row_t;

  typedef enum logic [1:0] { STALL_NONE, STALL_LIGHT, STALL_HEAVY } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [DEPTH_W-1:0]     depth_mm = '0;
  logic [MASK_W-1:0]      mask_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   point_valid;
  logic signed [XY_W-1:0] point_x;
  logic signed [XY_W-1:0] point_y;
  logic [Z_W-1:0]         point_z;
  logic                   frame_last;

  // model copy of the registers and raster counters
  logic [SIZE_W-1:0]      img_width;
  logic [SIZE_W-1:0]      img_height;
  logic [CENTER_W-1:0]    ctr_col_q4;
  logic [CENTER_W-1:0]    ctr_row_q4;
  logic [INV_W-1:0]       rcp_focal_col;
  logic [INV_W-1:0]       rcp_focal_row;
  logic [RASTER_BITS-1:0] pix_col;
  logic [RASTER_BITS-1:0] pix_row;

  point_t      pending_points[$];  // points owed by the unit, oldest first
  plan_row_t   dir_plan[$];
  int          mismatch_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  masked_depth_deprojection_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .depth_mm    (depth_mm),
    .mask_value  (mask_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_valid (point_valid),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .frame_last  (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // zero or oversized image dimension behaves as the full counter range
  function automatic logic [SIZE_W-1:0] raster_span(input logic [SIZE_W-1:0] s);
    return (s == '0 || s > RASTER_SPAN) ? RASTER_SPAN : s;
  endfunction

  // (coord*16 - center) * depth * rcp in 1/256 mm, round half up, clamp to 37 bits
  function automatic logic [XY_W-1:0] project_axis(input logic [RASTER_BITS-1:0] coord,
                                                   input logic [CENTER_W-1:0] center,
                                                   input logic [DEPTH_W-1:0] depth,
                                                   input logic [INV_W-1:0] rcp);
    logic [63:0] pos;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] mag_out;
    logic        below;
    pos   = 64'(coord) << 4;
    below = 64'(center) > pos;
    mag   = below ? 64'(center) - pos : pos - 64'(center);
    prod  = mag * 64'(depth) * 64'(rcp);
    if (!below) begin
      mag_out = (prod + ROUND_HALF) >> OUT_SHIFT;
      return (mag_out > SAT_POS) ? SAT_POS[XY_W-1:0] : mag_out[XY_W-1:0];
    end
    // negative side: ties go toward plus infinity, so the magnitude rounds down on a tie
    mag_out = (prod + ROUND_HALF - 64'd1) >> OUT_SHIFT;
    if (mag_out > SAT_NEG) mag_out = SAT_NEG;
    return XY_W'(64'd0 - mag_out);
  endfunction

  // expected point for one pixel word, then step the raster counters
  function automatic point_t predict_point(input logic [DEPTH_W-1:0] depth,
                                           input logic [MASK_W-1:0] mask);
    point_t            p;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              end_col;
    logic              end_row;
    w       = raster_span(img_width);
    h       = raster_span(img_height);
    end_col = {1'b0, pix_col} == w - SIZE_W'(1);
    end_row = {1'b0, pix_row} == h - SIZE_W'(1);
    p.vld   = (mask == MASK_OBJECT) && (depth != '0);
    if (p.vld) begin
      p.x = project_axis(pix_col, ctr_col_q4, depth, rcp_focal_col);
      p.y = project_axis(pix_row, ctr_row_q4, depth, rcp_focal_row);
      p.z = {depth, 8'h00};
    end else begin
      p.x = '0;
      p.y = '0;
      p.z = '0;
    end
    p.last = end_col && end_row;
    if (end_col) begin
      pix_col = '0;
      pix_row = end_row ? '0 : pix_row + 1'b1;
    end else begin
      pix_col = pix_col + 1'b1;
    end
    return p;
  endfunction

  function automatic plan_row_t pix(input logic [DEPTH_W-1:0] d, input logic [MASK_W-1:0] m);
    plan_row_t r;
    r.kind    = ROW_PIXEL;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.depth   = d;
    r.mask    = m;
    r.known   = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t pix_known(input logic [DEPTH_W-1:0] d,
                                          input logic [MASK_W-1:0] m, input logic v,
                                          input longint x, input longint y, input int z,
                                          input logic last);
    plan_row_t r;
    r           = pix(d, m);
    r.known     = 1'b1;
    r.want.vld  = v;
    r.want.x    = XY_W'(x);
    r.want.y    = XY_W'(y);
    r.want.z    = Z_W'(z);
    r.want.last = last;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t r;
    r         = pix('0, '0);
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // principal point: edges of the Q12.4 range, near the raster middle, or anywhere
  function automatic logic [CENTER_W-1:0] pick_center(input logic [SIZE_W-1:0] span);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return CENTER_W'(int'(span) * 8 + int'($urandom_range(0, 63)));
      default: return CENTER_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // focal reciprocal: zero, all ones, anything, or a typical lens
  function automatic logic [INV_W-1:0] pick_rcp();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return INV_W'($urandom_range(0, 32'h1FF_FFFF));
      default: return INV_W'($urandom_range(32'h1000, 32'h4_0000));
    endcase
  endfunction

  // one register write, then the write enable is dropped before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   img_width     = val[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:  img_height    = val[SIZE_W-1:0];
      REG_CENTER_COL_Q4: ctr_col_q4    = val[CENTER_W-1:0];
      REG_CENTER_ROW_Q4: ctr_row_q4    = val[CENTER_W-1:0];
      REG_INV_FOCAL_COL: rcp_focal_col = val[INV_W-1:0];
      REG_INV_FOCAL_ROW: rcp_focal_row = val[INV_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold one pixel word until taken; valid is left high for the caller
  task automatic put_word(input logic [DEPTH_W-1:0] d, input logic [MASK_W-1:0] m,
                          output point_t p);
    in_valid   <= 1'b1;
    depth_mm   <= d;
    mask_value <= m;
    do @(posedge clk); while (in_stall);
    p = predict_point(d, m);
  endtask

  // append one owed point at the back of the queue
  task automatic owe_point(input point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  // stop sending and wait until every owed point has come out
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random pixel words in bursts, with gaps and the odd full drain
  task automatic stream_pixels(input int count);
    int                 left;
    int                 burst;
    logic [DEPTH_W-1:0] d;
    logic [MASK_W-1:0]  m;
    point_t             p;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0: d = '0;
          1: d = '1;
          2: d = DEPTH_W'(1);
          default: d = DEPTH_W'($urandom_range(0, 16'hFFFF));
        endcase
        // mostly object pixels, plus near misses on the mask byte
        case ($urandom_range(0, 9))
          0: m = MASK_OBJECT - 1'b1;
          1: m = '0;
          2, 3: m = MASK_W'($urandom_range(0, 255));
          default: m = MASK_OBJECT;
        endcase
        put_word(d, m, p);
        owe_point(p);
      end
      left -= burst;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: ;  // back to back, no gap
        8: settle_block();
        default: begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      endcase
    end
  endtask

  task automatic check_point(input logic vld, input logic signed [XY_W-1:0] x,
                             input logic signed [XY_W-1:0] y, input logic [Z_W-1:0] z,
                             input logic last);
    point_t want;
    if (pending_points.size() == 0) begin
      $error("point word with no pixel waiting for it");
      mismatch_count++;
    end else begin
      want = pending_points.pop_front();
      if (vld !== want.vld) begin
        $error("point_valid: expected %0d, got %0d", want.vld, vld);
        mismatch_count++;
      end
      if (x !== want.x) begin
        $error("point_x: expected %0d, got %0d", want.x, x);
        mismatch_count++;
      end
      if (y !== want.y) begin
        $error("point_y: expected %0d, got %0d", want.y, y);
        mismatch_count++;
      end
      if (z !== want.z) begin
        $error("point_z: expected %0d, got %0d", want.z, z);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("frame_last: expected %0d, got %0d", want.last, last);
        mismatch_count++;
      end
    end
  endtask

  // receiver: check taken point words, stall in stretches of none, light and heavy
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_point(point_valid, point_x, point_y, point_z, frame_last);
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  initial begin
    plan_row_t         row;
    point_t            p;
    logic [SIZE_W-1:0] w_new;
    logic [SIZE_W-1:0] h_new;

    img_width     = IMAGE_WIDTH_RST;
    img_height    = IMAGE_HEIGHT_RST;
    ctr_col_q4    = CENTER_COL_RST;
    ctr_row_q4    = CENTER_ROW_RST;
    rcp_focal_col = INV_FOCAL_COL_RST;
    rcp_focal_row = INV_FOCAL_ROW_RST;
    pix_col       = '0;
    pix_row       = '0;

    // directed table; comments give the raster position of some pixels or what a row tests
    dir_plan = '{
      // reset registers: 640 x 480 frame
      pix_known(16'd0, MASK_OBJECT, 1'b0, 0, 0, 0, 1'b0),      // no depth reading
      pix_known(16'd1000, 8'd254, 1'b0, 0, 0, 0, 1'b0),        // mask one short of object
      pix_known(16'd1000, 8'd0, 1'b0, 0, 0, 0, 1'b0),          // background mask
      pix(16'd1000, MASK_OBJECT),                              // default lens, col 3
      // 5 x 2 frame, center at origin, unit reciprocal: x = col*d*256, y = row*d*256
      reg_row(REG_IMAGE_WIDTH, 25'd5),
      reg_row(REG_IMAGE_HEIGHT, 25'd2),
      reg_row(REG_CENTER_COL_Q4, 25'd0),
      reg_row(REG_CENTER_ROW_Q4, 25'd0),
      reg_row(REG_INV_FOCAL_COL, RCP_UNITY),
      reg_row(REG_INV_FOCAL_ROW, RCP_UNITY),
      pix_known(16'd1, MASK_OBJECT, 1'b1, 1024, 0, 256, 1'b0),               // col 4 row 0
      pix_known(16'hFFFF, MASK_OBJECT, 1'b1, 0, 16776960, 16776960, 1'b0),   // col 0 row 1
      pix_known(16'hFFFF, MASK_OBJECT, 1'b1, 16776960, 16776960, 16776960, 1'b0),
      pix_known(16'd2, MASK_OBJECT, 1'b1, 1024, 512, 512, 1'b0),             // col 2 row 1
      pix_known(16'd7, 8'd128, 1'b0, 0, 0, 0, 1'b0),
      pix_known(16'd0, MASK_OBJECT, 1'b0, 0, 0, 0, 1'b1),      // last pixel, still flagged
      // writes past the register list, then exact half steps: 1/16 px center, rcp 1/32
      reg_row(REG_NONE_A, 25'd0),
      reg_row(REG_NONE_B, 25'd0),
      reg_row(REG_CENTER_COL_Q4, 25'd1),
      reg_row(REG_INV_FOCAL_COL, RCP_TIE),
      pix_known(16'd3, MASK_OBJECT, 1'b1, -1, 0, 768, 1'b0),   // -1.5 goes to -1
      pix_known(16'd1, MASK_OBJECT, 1'b1, 8, 0, 256, 1'b0),    // 7.5 goes to 8
      // far center and largest reciprocal: x clamps low; zero row reciprocal gives y = 0
      reg_row(REG_CENTER_COL_Q4, 25'hFFFF),
      reg_row(REG_CENTER_ROW_Q4, 25'hFFFF),
      reg_row(REG_INV_FOCAL_COL, 25'h1FF_FFFF),
      reg_row(REG_INV_FOCAL_ROW, 25'd0),
      pix_known(16'hFFFF, MASK_OBJECT, 1'b1, XY_FLOOR, 0, 16776960, 1'b0),
      pix_known(16'd0, 8'd0, 1'b0, 0, 0, 0, 1'b0),
      // zero width and oversized height both mean the full counter range
      reg_row(REG_IMAGE_WIDTH, 25'd0),
      reg_row(REG_IMAGE_HEIGHT, 25'h1FFF),
      pix(16'd40000, MASK_OBJECT),
      pix(16'hFFFF, MASK_OBJECT)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) begin
      row = dir_plan[i];
      if (row.kind == ROW_WRITE) begin
        settle_block();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        put_word(row.depth, row.mask, p);
        owe_point(row.known ? row.want : p);
      end
    end

    // random register sets, small frames so frame ends come often
    for (int phase = 0; phase < 12; phase++) begin
      settle_block();
      w_new = (phase < 2) ? SIZE_W'(1) : SIZE_W'($urandom_range(1, 9));
      h_new = (phase < 2) ? SIZE_W'(1) : SIZE_W'($urandom_range(1, 5));
      // keep the counters inside the new frame so they wrap there
      if (w_new <= {1'b0, pix_col}) w_new = {1'b0, pix_col} + 1'b1;
      if (h_new <= {1'b0, pix_row}) h_new = {1'b0, pix_row} + 1'b1;
      // junk above the register width must be dropped
      write_reg(REG_IMAGE_WIDTH, {12'($urandom_range(0, 4095)), w_new});
      write_reg(REG_IMAGE_HEIGHT, {12'($urandom_range(0, 4095)), h_new});
      write_reg(REG_CENTER_COL_Q4, {9'($urandom_range(0, 511)), pick_center(w_new)});
      write_reg(REG_CENTER_ROW_Q4, {9'($urandom_range(0, 511)), pick_center(h_new)});
      write_reg(REG_INV_FOCAL_COL, pick_rcp());
      write_reg(REG_INV_FOCAL_ROW, pick_rcp());
      write_reg($urandom_range(0, 1) ? REG_NONE_A : REG_NONE_B, CFG_W'($urandom));
      stream_pixels($urandom_range(40, 90));
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    // any extra point word in this window is flagged by the receiver
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // watchdog, ends a run that has not finished as NOT OK
  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
